### hw/rtl/aiv_pkg.sv
// Types, codes and constants shared by the archive index validator.
`timescale 1ns / 1ps
package aiv_pkg;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [3:0]  status;
		logic [31:0] entry_index;
		logic [31:0] name_length;
		logic [31:0] stamp;
		logic [31:0] payload_bytes;
		logic [31:0] name_digest;
		logic [31:0] content_digest;
		logic [31:0] payload_start;
		logic [31:0] archive_digest;
		logic [31:0] entries_total;
	} out_word_t;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_RECORD  = 5'b00010,
		PH_TERM    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT     = 4'd1;
	localparam logic [3:0] ST_SIGNATURE = 4'd2;
	localparam logic [3:0] ST_VERSION   = 4'd3;
	localparam logic [3:0] ST_SIZE      = 4'd4;
	localparam logic [3:0] ST_OFFSET    = 4'd5;
	localparam logic [3:0] ST_COUNT     = 4'd6;
	localparam logic [3:0] ST_REC_HDR   = 4'd7;
	localparam logic [3:0] ST_REC_SMALL = 4'd8;
	localparam logic [3:0] ST_REC_LONG  = 4'd9;
	localparam logic [3:0] ST_NAME_CHAR = 4'd10;
	localparam logic [3:0] ST_NAME_NUL  = 4'd11;
	localparam logic [3:0] ST_INDEX_END = 4'd12;
	localparam logic [3:0] ST_PAYLOAD   = 4'd13;

	localparam logic        KIND_RECORD  = 1'b0;
	localparam logic        KIND_VERDICT = 1'b1;

	localparam logic [31:0] HDR_END      = 32'h25;
	localparam logic [31:0] REC_OVERHEAD = 32'd21;
	localparam logic [32:0] POS_CAP      = 33'h1_FFFF_FFFF;
	localparam logic [33:0] SUM_CAP      = 34'h2_0000_0000;
	localparam logic [32:0] POS_VERSION  = 33'h0C;
	localparam logic [32:0] POS_START    = 33'h10;
	localparam logic [32:0] POS_LENGTH   = 33'h14;
	localparam logic [32:0] POS_STAMP    = 33'h18;
	localparam logic [32:0] POS_DIGEST   = 33'h20;
	localparam logic [32:0] POS_ENTRIES  = 33'h24;
	localparam logic [32:0] SIG_LEN      = 33'd12;
	localparam logic [7:0]  NAME_LO      = 8'h20;
	localparam logic [7:0]  NAME_HI      = 8'h7E;

	function automatic logic [7:0] signature_byte(input logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd0:    v = 8'hAB;
			4'd1:    v = 8'h53;
			4'd2:    v = 8'h57;
			4'd3:    v = 8'h56;
			4'd4:    v = 8'h41;
			4'd5:    v = 8'h52;
			4'd6:    v = 8'h43;
			4'd7:    v = 8'hBB;
			4'd8:    v = 8'h0D;
			4'd9:    v = 8'h0A;
			4'd10:   v = 8'h1A;
			4'd11:   v = 8'h0A;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/archive_index_validator.sv
// Top level of the archive index validator: byte queue, walker, result queue.
//
//   channel  handshake        word
//   item     push / full      file_byte, end_of_file
//   result   pop / empty      record metadata or final verdict
//
// One file byte per cycle; the walker takes a byte whenever the byte queue holds one
// and the result queue has room. An unstalled byte reaches the walker in the cycle after
// it is pushed; its result word is written at the edge that ends that cycle and shows right after it.
// Reset clears both queues and returns the walker to the start of a file.
// A stalled result side backs up the result queue, then the walker, then the byte queue.
`timescale 1ns / 1ps
module archive_index_validator #(
	parameter int IN_DEPTH  = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  aiv_pkg::in_word_t  item,
	output logic               empty,
	input  logic               pop,
	output aiv_pkg::out_word_t result
);
	localparam int IW = $bits(aiv_pkg::in_word_t);
	localparam int OW = $bits(aiv_pkg::out_word_t);

	logic               byte_empty;
	logic [IW-1:0]      byte_data;
	aiv_pkg::in_word_t  byte_word;
	logic               res_full;
	logic               fire;
	logic               res_valid;
	aiv_pkg::out_word_t res_word;
	logic [OW-1:0]      res_data;

	aiv_fifo #(.WIDTH(IW), .DEPTH(IN_DEPTH)) u_byte_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (item),
		.full    (full),
		.rd_en   (fire),
		.rd_data (byte_data),
		.empty   (byte_empty)
	);

	assign byte_word = aiv_pkg::in_word_t'(byte_data);
	assign fire      = !byte_empty && !res_full;

	aiv_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.word      (byte_word),
		.res_valid (res_valid),
		.res       (res_word)
	);

	aiv_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fire && res_valid),
		.wr_data (res_word),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_data),
		.empty   (empty)
	);

	assign result = aiv_pkg::out_word_t'(res_data);
endmodule

### hw/rtl/aiv_fifo.sv
// Small word queue with registered storage.
`timescale 1ns / 1ps
module aiv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

### hw/rtl/aiv_walk.sv
// Header check, index walk and verdict: one file byte per cycle while fire is high.
`timescale 1ns / 1ps
module aiv_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  aiv_pkg::in_word_t word,
	output logic              res_valid,
	output aiv_pkg::out_word_t res
);
	logic [32:0]     pos_q;
	logic [3:0]      ff_q;
	logic [31:0]     ws_q;
	logic [31:0]     start_q;
	logic [31:0]     dlen_q;
	logic [31:0]     astamp_q;
	logic [31:0]     hdig_q;
	logic [31:0]     ents_q;
	logic [31:0]     seen_q;
	logic [31:0]     base_q;
	logic [31:0]     rlen_q;
	logic [31:0]     fld_q [4];
	logic [33:0]     psum_q;
	aiv_pkg::phase_t ph_q;

	logic [3:0]      nx_ff;
	logic [31:0]     ws_n;
	logic [31:0]     nx_start;
	logic [31:0]     nx_dlen;
	logic [31:0]     nx_astamp;
	logic [31:0]     nx_hdig;
	logic [31:0]     nx_ents;
	logic [31:0]     nx_seen;
	logic [31:0]     nx_base;
	logic [31:0]     nx_rlen;
	logic [31:0]     nx_fld [4];
	logic [33:0]     nx_psum;
	aiv_pkg::phase_t nx_ph;

	logic [7:0]      b;
	logic [33:0]     r;
	logic [32:0]     idx_end;
	logic [33:0]     nlen;
	logic [33:0]     sum_raw;
	logic [33:0]     len;
	logic [36:0]     ents22;
	logic [33:0]     room;
	logic [3:0]      vst;

	assign b       = word.file_byte;
	assign r       = {1'b0, pos_q} - {2'b0, base_q};
	assign idx_end = {1'b0, start_q} - 33'd1;
	assign nlen    = {2'b0, rlen_q} - {2'b0, aiv_pkg::REC_OVERHEAD};
	assign len     = {1'b0, pos_q} + 34'd1;
	assign ents22  = {1'b0, ws_n, 4'b0} + {3'b0, ws_n, 2'b0} + {4'b0, ws_n, 1'b0};
	assign room    = {1'b0, idx_end} - {2'b0, base_q};

	always_comb begin
		ws_n      = {b, ws_q[31:8]};
		nx_ff     = ff_q;
		nx_start  = start_q;
		nx_dlen   = dlen_q;
		nx_astamp = astamp_q;
		nx_hdig   = hdig_q;
		nx_ents   = ents_q;
		nx_seen   = seen_q;
		nx_base   = base_q;
		nx_rlen   = rlen_q;
		nx_fld    = fld_q;
		nx_psum   = psum_q;
		nx_ph     = ph_q;
		sum_raw   = psum_q + {2'b0, fld_q[1]};
		res_valid = 1'b0;
		res       = '0;
		vst       = aiv_pkg::ST_OK;

		unique case (ph_q)
			aiv_pkg::PH_HEADER: begin
				if (pos_q < aiv_pkg::SIG_LEN && b != aiv_pkg::signature_byte(pos_q[3:0])
						&& nx_ff == aiv_pkg::ST_OK) begin
					nx_ff = aiv_pkg::ST_SIGNATURE;
				end
				if (pos_q == aiv_pkg::POS_VERSION && b != 8'd0 && nx_ff == aiv_pkg::ST_OK) begin
					nx_ff = aiv_pkg::ST_VERSION;
				end
				if (pos_q == aiv_pkg::POS_START) nx_start = ws_n;
				if (pos_q == aiv_pkg::POS_LENGTH) nx_dlen = ws_n;
				if (pos_q == aiv_pkg::POS_STAMP) nx_astamp = ws_n;
				if (pos_q == aiv_pkg::POS_DIGEST) nx_hdig = ws_n;
				if (pos_q == aiv_pkg::POS_ENTRIES) begin
					nx_ents = ws_n;
					if (nx_ff == aiv_pkg::ST_OK) begin
						if (start_q <= aiv_pkg::HDR_END || start_q > dlen_q) begin
							nx_ff = aiv_pkg::ST_OFFSET;
						end else if (ws_n == 32'd0 ||
								ents22 > {5'b0, start_q - aiv_pkg::HDR_END - 32'd1}) begin
							nx_ff = aiv_pkg::ST_COUNT;
						end
					end
					nx_psum = {2'b0, start_q};
					nx_base = aiv_pkg::HDR_END;
					nx_ph   = (nx_ff == aiv_pkg::ST_OK) ? aiv_pkg::PH_RECORD
						: aiv_pkg::PH_SKIP;
				end
			end
			aiv_pkg::PH_RECORD: begin
				if (r == 34'd0 && ({1'b0, base_q} + 33'd16) > idx_end) begin
					if (nx_ff == aiv_pkg::ST_OK) nx_ff = aiv_pkg::ST_REC_HDR;
					nx_ph = aiv_pkg::PH_SKIP;
				end else if (r == 34'd3) begin
					nx_rlen = ws_n;
					if (ws_n <= aiv_pkg::REC_OVERHEAD) begin
						if (nx_ff == aiv_pkg::ST_OK) nx_ff = aiv_pkg::ST_REC_SMALL;
						nx_ph = aiv_pkg::PH_SKIP;
					end else if ({2'b0, ws_n} > room) begin
						if (nx_ff == aiv_pkg::ST_OK) nx_ff = aiv_pkg::ST_REC_LONG;
						nx_ph = aiv_pkg::PH_SKIP;
					end
				end else if (r == 34'd7) begin
					nx_fld[0] = ws_n;
				end else if (r == 34'd11) begin
					nx_fld[1] = ws_n;
				end else if (r == 34'd15) begin
					nx_fld[2] = ws_n;
				end else if (r >= 34'd16) begin
					if (r < nlen + 34'd16) begin
						if (b < aiv_pkg::NAME_LO || b > aiv_pkg::NAME_HI) begin
							if (nx_ff == aiv_pkg::ST_OK) nx_ff = aiv_pkg::ST_NAME_CHAR;
							nx_ph = aiv_pkg::PH_SKIP;
						end
					end else if (r == nlen + 34'd16) begin
						if (b != 8'd0) begin
							if (nx_ff == aiv_pkg::ST_OK) nx_ff = aiv_pkg::ST_NAME_NUL;
							nx_ph = aiv_pkg::PH_SKIP;
						end
					end else if (r == {2'b0, rlen_q} - 34'd1) begin
						nx_fld[3]           = ws_n;
						res_valid           = 1'b1;
						res.result_kind     = aiv_pkg::KIND_RECORD;
						res.status          = aiv_pkg::ST_OK;
						res.entry_index     = seen_q;
						res.name_length     = nlen[31:0];
						res.stamp           = fld_q[0];
						res.payload_bytes   = fld_q[1];
						res.name_digest     = fld_q[2];
						res.content_digest  = ws_n;
						res.payload_start   = psum_q[31:0];
						nx_psum = (sum_raw > aiv_pkg::SUM_CAP) ? aiv_pkg::SUM_CAP : sum_raw;
						nx_seen = seen_q + 32'd1;
						nx_base = base_q + rlen_q;
						if (nx_seen == ents_q) begin
							if ({1'b0, nx_base} != idx_end) begin
								if (nx_ff == aiv_pkg::ST_OK) nx_ff = aiv_pkg::ST_INDEX_END;
								nx_ph = aiv_pkg::PH_SKIP;
							end else begin
								nx_ph = aiv_pkg::PH_TERM;
							end
						end
					end
				end
			end
			aiv_pkg::PH_TERM: begin
				if (b != 8'd0) begin
					if (nx_ff == aiv_pkg::ST_OK) nx_ff = aiv_pkg::ST_INDEX_END;
					nx_ph = aiv_pkg::PH_SKIP;
				end else begin
					nx_ph = aiv_pkg::PH_PAYLOAD;
				end
			end
			aiv_pkg::PH_PAYLOAD: begin
			end
			aiv_pkg::PH_SKIP: begin
			end
			default: begin
			end
		endcase

		if (word.end_of_file) begin
			if (len <= {2'b0, aiv_pkg::HDR_END}) begin
				vst = aiv_pkg::ST_SHORT;
			end else if (nx_ff == aiv_pkg::ST_SIGNATURE || nx_ff == aiv_pkg::ST_VERSION) begin
				vst = nx_ff;
			end else if (len != {2'b0, nx_dlen}) begin
				vst = aiv_pkg::ST_SIZE;
			end else if (nx_ff != aiv_pkg::ST_OK) begin
				vst = nx_ff;
			end else if (nx_ph != aiv_pkg::PH_PAYLOAD) begin
				vst = aiv_pkg::ST_INDEX_END;
			end else if (nx_psum != len) begin
				vst = aiv_pkg::ST_PAYLOAD;
			end
			res_valid          = 1'b1;
			res                = '0;
			res.result_kind    = aiv_pkg::KIND_VERDICT;
			res.status         = vst;
			res.entry_index    = nx_seen;
			res.stamp          = nx_astamp;
			res.payload_start  = nx_start;
			res.archive_digest = nx_hdig;
			res.entries_total  = nx_ents;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ff_q     <= aiv_pkg::ST_OK;
			ws_q     <= '0;
			start_q  <= '0;
			dlen_q   <= '0;
			astamp_q <= '0;
			hdig_q   <= '0;
			ents_q   <= '0;
			seen_q   <= '0;
			base_q   <= aiv_pkg::HDR_END;
			rlen_q   <= '0;
			fld_q    <= '{default: '0};
			psum_q   <= '0;
			ph_q     <= aiv_pkg::PH_HEADER;
		end else if (fire) begin
			if (word.end_of_file) begin
				pos_q    <= '0;
				ff_q     <= aiv_pkg::ST_OK;
				ws_q     <= '0;
				start_q  <= '0;
				dlen_q   <= '0;
				astamp_q <= '0;
				hdig_q   <= '0;
				ents_q   <= '0;
				seen_q   <= '0;
				base_q   <= aiv_pkg::HDR_END;
				rlen_q   <= '0;
				fld_q    <= '{default: '0};
				psum_q   <= '0;
				ph_q     <= aiv_pkg::PH_HEADER;
			end else begin
				pos_q    <= (pos_q == aiv_pkg::POS_CAP) ? pos_q : pos_q + 33'd1;
				ff_q     <= nx_ff;
				ws_q     <= ws_n;
				start_q  <= nx_start;
				dlen_q   <= nx_dlen;
				astamp_q <= nx_astamp;
				hdig_q   <= nx_hdig;
				ents_q   <= nx_ents;
				seen_q   <= nx_seen;
				base_q   <= nx_base;
				rlen_q   <= nx_rlen;
				fld_q    <= nx_fld;
				psum_q   <= nx_psum;
				ph_q     <= nx_ph;
			end
		end
	end
endmodule

### tb/sv/tb_archive_index_validator.sv
// Self-checking testbench for the archive index validator: archive stimulus and checks.
`timescale 1ns / 1ps
module tb_archive_index_validator;
	import aiv_pkg::*;

	typedef struct {
		in_word_t w;
		bit       hold;
	} pend_t;

	localparam logic [7:0] SIG [12] = '{8'hAB, 8'h53, 8'h57, 8'h56, 8'h41, 8'h52,
		8'h43, 8'hBB, 8'h0D, 8'h0A, 8'h1A, 8'h0A};

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_word_t  item;
	logic      empty;
	logic      pop;
	out_word_t result;

	pend_t     byte_queue[$];
	out_word_t result_queue[$];
	int        mismatches;
	int        tx_gap;
	int        rx_gap;
	bit        quiet;

	logic [32:0] at_pos;
	logic [3:0]  fault;
	logic [31:0] shreg;
	logic [31:0] area_start;
	logic [31:0] decl_len;
	logic [31:0] arc_stamp;
	logic [31:0] hdr_digest;
	logic [31:0] decl_entries;
	logic [31:0] rec_count;
	logic [31:0] rec_base;
	logic [31:0] rec_len;
	logic [31:0] rec_word [4];
	logic [33:0] pay_sum;
	phase_t      phase;

	archive_index_validator DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void expect_word(out_word_t o);
		result_queue.insert(result_queue.size(), o);
	endfunction

	function automatic void queue_pend(pend_t e);
		byte_queue.insert(byte_queue.size(), e);
	endfunction

	function automatic void add_byte(ref logic [7:0] f[$], input logic [7:0] v);
		f.insert(f.size(), v);
	endfunction

	function automatic void clear_walker();
		at_pos = '0;
		fault = ST_OK;
		shreg = '0;
		area_start = '0;
		decl_len = '0;
		arc_stamp = '0;
		hdr_digest = '0;
		decl_entries = '0;
		rec_count = '0;
		rec_base = HDR_END;
		rec_len = '0;
		foreach (rec_word[i]) rec_word[i] = '0;
		pay_sum = '0;
		phase = PH_HEADER;
	endfunction

	function automatic void note_fault(logic [3:0] code);
		if (fault == ST_OK) fault = code;
		phase = PH_SKIP;
	endfunction

	function automatic bit walk_index(input logic [7:0] b, input logic [63:0] p,
			output out_word_t o);
		logic [63:0] r;
		logic [63:0] idx_end;
		logic [63:0] nlen;
		bit          hit;
		hit = 1'b0;
		o = '0;
		r = p - rec_base;
		idx_end = {32'b0, area_start} - 64'd1;
		nlen = {32'b0, rec_len} - REC_OVERHEAD;
		if (r == 0 && {32'b0, rec_base} + 64'd16 > idx_end) begin
			note_fault(ST_REC_HDR);
		end else if (r == 3) begin
			rec_len = shreg;
			if (rec_len < REC_OVERHEAD + 1) note_fault(ST_REC_SMALL);
			else if ({32'b0, rec_len} > idx_end - rec_base) note_fault(ST_REC_LONG);
		end else if (r == 7) begin
			rec_word[0] = shreg;
		end else if (r == 11) begin
			rec_word[1] = shreg;
		end else if (r == 15) begin
			rec_word[2] = shreg;
		end else if (r >= 16) begin
			if (r < 64'd16 + nlen) begin
				if (b < NAME_LO || b > NAME_HI) note_fault(ST_NAME_CHAR);
			end else if (r == 64'd16 + nlen) begin
				if (b != 8'h00) note_fault(ST_NAME_NUL);
			end else if (r == {32'b0, rec_len} - 64'd1) begin
				rec_word[3] = shreg;
				hit = 1'b1;
				o.result_kind = KIND_RECORD;
				o.status = ST_OK;
				o.entry_index = rec_count;
				o.name_length = nlen[31:0];
				o.stamp = rec_word[0];
				o.payload_bytes = rec_word[1];
				o.name_digest = rec_word[2];
				o.content_digest = rec_word[3];
				o.payload_start = pay_sum[31:0];
				pay_sum = pay_sum + rec_word[1];
				if (pay_sum > SUM_CAP) pay_sum = SUM_CAP;
				rec_count = rec_count + 1;
				rec_base = rec_base + rec_len;
				if (rec_count == decl_entries) begin
					if ({32'b0, rec_base} != idx_end) note_fault(ST_INDEX_END);
					else phase = PH_TERM;
				end
			end
		end
		return hit;
	endfunction

	function automatic void predict_byte(in_word_t w);
		logic [7:0]  b;
		logic [32:0] p;
		logic [33:0] flen;
		out_word_t   o;
		out_word_t   rec_o;
		bit          got;
		b = w.file_byte;
		p = at_pos;
		got = 1'b0;
		rec_o = '0;
		shreg = {b, shreg[31:8]};
		case (phase)
			PH_HEADER: begin
				if (p < SIG_LEN && b != SIG[p[3:0]] && fault == ST_OK) fault = ST_SIGNATURE;
				if (p == POS_VERSION && b != 8'h00 && fault == ST_OK) fault = ST_VERSION;
				if (p == POS_START) area_start = shreg;
				if (p == POS_LENGTH) decl_len = shreg;
				if (p == POS_STAMP) arc_stamp = shreg;
				if (p == POS_DIGEST) hdr_digest = shreg;
				if (p == POS_ENTRIES) begin
					decl_entries = shreg;
					if (fault == ST_OK) begin
						if (area_start < HDR_END + 1 || area_start > decl_len)
							fault = ST_OFFSET;
						else if (decl_entries == 0 ||
								decl_entries > (area_start - HDR_END - 1) / (REC_OVERHEAD + 1))
							fault = ST_COUNT;
					end
					pay_sum = {2'b0, area_start};
					rec_base = HDR_END;
					phase = (fault == ST_OK) ? PH_RECORD : PH_SKIP;
				end
			end
			PH_RECORD: got = walk_index(b, {31'b0, p}, rec_o);
			PH_TERM: begin
				if (b != 8'h00) note_fault(ST_INDEX_END);
				else phase = PH_PAYLOAD;
			end
			default: ;
		endcase
		if (at_pos < POS_CAP) at_pos = at_pos + 1;
		if (w.end_of_file) begin
			flen = {1'b0, p} + 34'd1;
			o = '0;
			o.result_kind = KIND_VERDICT;
			if (flen < HDR_END + 1) o.status = ST_SHORT;
			else if (fault == ST_SIGNATURE || fault == ST_VERSION) o.status = fault;
			else if (flen != {2'b0, decl_len}) o.status = ST_SIZE;
			else if (fault != ST_OK) o.status = fault;
			else if (phase != PH_PAYLOAD) o.status = ST_INDEX_END;
			else if (pay_sum != flen) o.status = ST_PAYLOAD;
			else o.status = ST_OK;
			o.entry_index = rec_count;
			o.stamp = arc_stamp;
			o.payload_start = area_start;
			o.archive_digest = hdr_digest;
			o.entries_total = decl_entries;
			expect_word(o);
			clear_walker();
		end else if (got) begin
			expect_word(rec_o);
		end
	endfunction

	function automatic void put_le(ref logic [7:0] f[$], input int at, input logic [31:0] v);
		for (int i = 0; i < 4; i++) f[at + i] = v[8 * i +: 8];
	endfunction

	// fault_sel: 0 none, 1..11 directed corruption, 12 random corruption
	function automatic void queue_archive(int fault_sel, bit hold);
		logic [7:0] f[$];
		int         n;
		int         nl [4];
		int         pb [4];
		int         start;
		int         total;
		int         at;
		int         c;
		logic [31:0] pw;
		pend_t      e;
		n = $urandom_range(1, 4);
		start = 38;
		total = 0;
		for (int i = 0; i < n; i++) begin
			nl[i] = $urandom_range(1, 6);
			pb[i] = $urandom_range(0, 8);
			start += 21 + nl[i];
			total += pb[i];
		end
		total += start;
		for (int i = 0; i < 37; i++) add_byte(f, 8'($urandom_range(0, 255)));
		for (int i = 0; i < 12; i++) f[i] = SIG[i];
		f[12] = 8'h00;
		put_le(f, 13, start);
		put_le(f, 17, total);
		put_le(f, 33, n);
		at = 37;
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 21 + nl[i]; k++) add_byte(f, 8'($urandom_range(0, 255)));
			put_le(f, at, 21 + nl[i]);
			pw = pb[i];
			if ($urandom_range(0, 11) == 0) pw = $urandom;
			put_le(f, at + 8, pw);
			for (int k = 0; k < nl[i]; k++) f[at + 16 + k] = $urandom_range(8'h20, 8'h7E);
			f[at + 16 + nl[i]] = 8'h00;
			at += 21 + nl[i];
		end
		add_byte(f, 8'h00);
		for (int i = 0; i < total - start; i++) add_byte(f, 8'($urandom_range(0, 255)));
		case (fault_sel)
			1: f[$urandom_range(0, 11)] ^= 8'h01 << $urandom_range(0, 7);
			2: f[12] = $urandom_range(1, 255);
			3: put_le(f, 13, $urandom_range(0, 37));
			4: put_le(f, 33, 0);
			5: put_le(f, 17, total + 1);
			6: put_le(f, 37, $urandom_range(0, 21));
			7: put_le(f, 37, 32'hFFFF_FFF0);
			8: f[37 + 16] = $urandom_range(0, 1) ? 8'h7F : 8'h1F;
			9: f[37 + 16 + nl[0]] = 8'h41;
			10: f[start - 1] = 8'h80;
			11: put_le(f, 37 + 8, pb[0] + 1);
			12: begin
				c = $urandom_range(0, 3);
				if (c == 0) f[$urandom_range(0, f.size() - 1)] = $urandom;
				else if (c == 1) f = f[0:$urandom_range(0, f.size() - 1)];
				else if (c == 2) for (int i = 0; i < 3; i++) add_byte(f, 8'($urandom));
				else put_le(f, 33, n + $urandom_range(0, 2) - 1);
			end
			default: ;
		endcase
		foreach (f[i]) begin
			e.w.file_byte = f[i];
			e.w.end_of_file = (i == f.size() - 1);
			e.hold = hold && i == 0;
			queue_pend(e);
		end
	endfunction

	function automatic void queue_noise(int len);
		pend_t e;
		for (int i = 0; i < len; i++) begin
			e.w.file_byte = $urandom;
			e.w.end_of_file = (i == len - 1);
			e.hold = 1'b0;
			queue_pend(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pend_t e;
		bit    sent;
		int    gap;
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			tx_gap <= 0;
		end else begin
			sent = push && !full;
			gap = tx_gap;
			if (sent) begin
				predict_byte(item);
				void'(byte_queue.pop_front());
				gap = quiet ? 0 : $urandom_range(0, 18);
			end
			if (push && !sent) begin
			end else if (gap > 0) begin
				push <= 1'b0;
				tx_gap <= gap - 1;
			end else if (byte_queue.size() > 0 &&
					!(byte_queue[0].hold && result_queue.size() > 0)) begin
				e = byte_queue[0];
				push <= 1'b1;
				item <= e.w;
				tx_gap <= 0;
			end else begin
				push <= 1'b0;
				tx_gap <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_word_t x;
		int        gap;
		if (!arst_n) begin
			pop <= 1'b0;
			rx_gap <= 0;
		end else begin
			gap = rx_gap;
			if (pop && !empty) begin
				if (result_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %p", result);
				end else begin
					x = result_queue.pop_front();
					if (result !== x) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word mismatch: expected %p actual %p", x, result);
					end
				end
				gap = quiet ? 0 : $urandom_range(0, 18);
			end
			if (gap > 0) begin
				pop <= 1'b0;
				rx_gap <= gap - 1;
			end else begin
				pop <= 1'b1;
				rx_gap <= 0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int wait_cycles;
		mismatches = 0;
		quiet = 1'b0;
		clear_walker();
		arst_n = 1'b0;
		for (int s = 0; s <= 11; s++) queue_archive(s, 1'b0);
		queue_noise(10);
		queue_noise(1);
		queue_archive(0, 1'b1);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (byte_queue.size() < 1550) begin
			if ($urandom_range(0, 5) == 0) queue_noise($urandom_range(1, 60));
			else queue_archive($urandom_range(0, 2) == 0 ? 12 : 0,
				$urandom_range(0, 15) == 0);
		end
		while (byte_queue.size() > 0) begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0) quiet = ~quiet;
		end
		quiet = 1'b0;
		wait_cycles = 0;
		while (result_queue.size() > 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && result_queue.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
